// ----- rtl/core/natural_log_series_macros.svh -----
// ----------------------------------------------------------------------------
// natural_log_series assertion macros
// Shared assertion forms for the checker of the logarithm block.
// ----------------------------------------------------------------------------
`ifndef NATURAL_LOG_SERIES_MACROS_SVH
`define NATURAL_LOG_SERIES_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define NLS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define NLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after reset is seen low
`define NLS_ASSERT_AFTER_RESET(lbl, clk, rst_n, cons, msg) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/nls_pkg.sv -----
// ----------------------------------------------------------------------------
// nls_pkg
// Types, widths, constants and sequencer states of the logarithm block.
// ----------------------------------------------------------------------------
package nls_pkg;

    // Fixed-point formats
    localparam int FRAC_BITS  = 16;
    localparam int INNER_FRAC = 30;
    localparam int WIDEN_SH   = INNER_FRAC - FRAC_BITS;

    // Field widths
    localparam int X_W   = 32;
    localparam int LOG_W = 32;
    localparam int TC_W  = 10;

    // Series length limit
    localparam int MAX_TERMS = 1023;

    // Internal widths
    localparam int A_W       = X_W + WIDEN_SH;
    localparam int B_W       = 5;
    localparam int V_W       = INNER_FRAC + 2;
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ACC_W     = 48;
    localparam int DIV_W     = 44;
    localparam int DIVISOR_W = TC_W;
    localparam int DIV_RADIX = 4;
    localparam int DIV_STEPS = DIV_W / DIV_RADIX;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef logic        [TC_W-1:0]      t_tc;
    typedef logic        [A_W-1:0]       t_a;
    typedef logic        [B_W-1:0]       t_b;
    typedef logic        [V_W-1:0]       t_v;
    typedef logic signed [MUL_W-1:0]     t_mul;
    typedef logic signed [PROD_W-1:0]    t_prod;
    typedef logic signed [ACC_W-1:0]     t_acc;
    typedef logic signed [LOG_W-1:0]     t_log;
    typedef logic        [DIV_W-1:0]     t_div;
    typedef logic        [DIVISOR_W-1:0] t_dsr;
    typedef logic        [DIV_CNT_W-1:0] t_div_cnt;

    // Typed constants
    localparam t_tc      TC_RESET      = t_tc'(64);
    localparam t_tc      MAX_TERMS_TC  = t_tc'(MAX_TERMS);
    localparam t_tc      FIRST_INDEX   = t_tc'(2);
    localparam t_v       ONE_V         = t_v'(1) << INNER_FRAC;
    localparam t_v       TWO_V         = t_v'(2) << INNER_FRAC;
    localparam t_a       TWO_A         = t_a'(2) << INNER_FRAC;
    localparam t_prod    PROD_RND      = t_prod'((t_prod'(1) <<< INNER_FRAC) - t_prod'(1));
    localparam t_acc     ACC_RND       = t_acc'((t_acc'(1) <<< WIDEN_SH) - t_acc'(1));
    localparam t_acc     ACC_LOG_MAX   = $signed({{(ACC_W-LOG_W+1){1'b0}}, {(LOG_W-1){1'b1}}});
    localparam t_acc     ACC_LOG_MIN   = $signed({{(ACC_W-LOG_W+1){1'b1}}, {(LOG_W-1){1'b0}}});
    localparam t_div_cnt DIV_LAST      = t_div_cnt'(DIV_STEPS - 1);

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SER_INIT,
        ST_CHECK,
        ST_MUL_C,
        ST_SCALE,
        ST_MUL_I,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MUL_B,
        ST_FINISH
    } t_state;

endpackage

// ----- rtl/core/natural_log_series.sv -----
// ----------------------------------------------------------------------------
// natural_log_series
// Natural logarithm of an unsigned Q16.16 value by a range-reduced series.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (i_valid/o_ready) carry i_x_value; result beats
//   (o_valid/i_ready) carry o_log_value and o_invalid, one per input beat.
//   A configuration beat (i_cfg_valid/o_cfg_ready) writes i_term_count;
//   o_cfg_ready is always high. Write it only while the block is idle.
//   The block takes one input at a time: o_ready is high only when the
//   sequencer is idle. A zero input goes straight to the finish state,
//   which raises o_valid once the result register is free. Otherwise x is
//   halved once per cycle until it is at most 2.0; then each series runs
//   term_count-2 further terms, each through the shared divider (eleven
//   steps and a done pulse) and the one shared multiplier.
//   An extra series at 2.0 runs first, only when x was above 2.0.
//   The result register frees the sequencer: a new input is accepted while
//   a finished result still waits; if the receiver stalls, the next result
//   is held in the sequencer until the register empties.
//   Reset sets term_count to 64, empties the result register and returns
//   the sequencer to idle.
// ----------------------------------------------------------------------------
module natural_log_series (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [nls_pkg::X_W-1:0]    i_x_value,
    // result channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [nls_pkg::LOG_W-1:0] o_log_value,
    output logic                       o_invalid,
    // configuration channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [nls_pkg::TC_W-1:0]   i_term_count
);

    nls_pkg::t_state r_state, n_state;

    nls_pkg::t_tc   r_term_count;
    nls_pkg::t_a    r_a, n_a;
    nls_pkg::t_b    r_b, n_b;
    logic           r_zero, n_zero;
    logic           r_phase_two, n_phase_two;
    nls_pkg::t_mul  r_el, n_el;
    nls_pkg::t_mul  r_c, n_c;
    nls_pkg::t_mul  r_t, n_t;
    nls_pkg::t_prod r_prod, n_prod;
    logic           r_neg, n_neg;
    nls_pkg::t_tc   r_i, n_i;
    nls_pkg::t_acc  r_sum, n_sum;
    nls_pkg::t_acc  r_total, n_total;
    nls_pkg::t_log  r_log, n_log;
    logic           r_inv, n_inv;
    logic           r_out_valid, n_out_valid;

    logic           in_beat;
    logic           slot_free;
    nls_pkg::t_tc   terms_eff;

    nls_pkg::t_mul  mul_x, mul_y;
    nls_pkg::t_prod mul_p;
    logic           div_start;
    nls_pkg::t_div  div_dividend;
    logic           div_done;
    nls_pkg::t_div  div_quo;

    nls_pkg::t_v    v_sel;
    logic [nls_pkg::V_W:0] el_diff;
    nls_pkg::t_mul  el_init;
    nls_pkg::t_prod prod_mag;
    nls_pkg::t_prod scale_sh;
    nls_pkg::t_mul  q_s;
    nls_pkg::t_mul  el_new;
    nls_pkg::t_acc  fin_sh;

    assign in_beat   = i_valid && o_ready;
    assign slot_free = !r_out_valid || i_ready;
    assign terms_eff = (r_term_count > nls_pkg::MAX_TERMS_TC) ? nls_pkg::MAX_TERMS_TC
                                                               : r_term_count;

    // Shared multiplier, product always registered by the caller
    assign mul_p = mul_x * mul_y;

    nls_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_i),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nls_pkg::ST_IDLE: begin
                if (in_beat) begin
                    n_state = (i_x_value == '0) ? nls_pkg::ST_FINISH : nls_pkg::ST_REDUCE;
                end
            end
            nls_pkg::ST_REDUCE: begin
                if (r_a <= nls_pkg::TWO_A) begin
                    n_state = nls_pkg::ST_SER_INIT;
                end
            end
            nls_pkg::ST_SER_INIT:  n_state = nls_pkg::ST_CHECK;
            nls_pkg::ST_CHECK: begin
                priority if (r_i < terms_eff) begin
                    n_state = nls_pkg::ST_MUL_C;
                end else if (r_phase_two) begin
                    n_state = nls_pkg::ST_MUL_B;
                end else begin
                    n_state = nls_pkg::ST_FINISH;
                end
            end
            nls_pkg::ST_MUL_C:     n_state = nls_pkg::ST_SCALE;
            nls_pkg::ST_SCALE:     n_state = nls_pkg::ST_MUL_I;
            nls_pkg::ST_MUL_I:     n_state = nls_pkg::ST_DIV_START;
            nls_pkg::ST_DIV_START: n_state = nls_pkg::ST_DIV_WAIT;
            nls_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = nls_pkg::ST_CHECK;
                end
            end
            nls_pkg::ST_MUL_B:     n_state = nls_pkg::ST_SER_INIT;
            nls_pkg::ST_FINISH: begin
                if (slot_free) begin
                    n_state = nls_pkg::ST_IDLE;
                end
            end
            default:               n_state = nls_pkg::ST_IDLE;
        endcase
    end

    // Unit controls and handshake outputs
    always_comb begin
        o_ready   = (r_state == nls_pkg::ST_IDLE);
        mul_x     = r_el;
        mul_y     = r_c;
        div_start = 1'b0;
        unique case (r_state)
            nls_pkg::ST_MUL_I: begin
                mul_x = r_t;
                mul_y = $signed({{(nls_pkg::MUL_W-nls_pkg::TC_W){1'b0}},
                                 r_i - nls_pkg::t_tc'(1)});
            end
            nls_pkg::ST_MUL_B: begin
                mul_x = nls_pkg::t_mul'(r_sum);
                mul_y = $signed({{(nls_pkg::MUL_W-nls_pkg::B_W){1'b0}}, r_b});
            end
            nls_pkg::ST_DIV_START: div_start = 1'b1;
            default: ;
        endcase
    end

    // Helper arithmetic for the datapath
    always_comb begin
        v_sel        = r_phase_two ? nls_pkg::TWO_V : nls_pkg::t_v'(r_a);
        el_diff      = {1'b0, v_sel} - {1'b0, nls_pkg::ONE_V};
        el_init      = nls_pkg::t_mul'(el_diff);
        scale_sh     = (r_prod + (r_prod[nls_pkg::PROD_W-1] ? nls_pkg::PROD_RND
                                                            : nls_pkg::t_prod'(0)))
                       >>> nls_pkg::INNER_FRAC;
        prod_mag     = r_prod[nls_pkg::PROD_W-1] ? -r_prod : r_prod;
        div_dividend = nls_pkg::t_div'(prod_mag);
        q_s          = nls_pkg::t_mul'(div_quo);
        el_new       = r_neg ? -q_s : q_s;
        fin_sh       = (r_sum + (r_sum[nls_pkg::ACC_W-1] ? nls_pkg::ACC_RND
                                                         : nls_pkg::t_acc'(0)))
                       >>> nls_pkg::WIDEN_SH;
    end

    // Datapath next values
    always_comb begin
        n_a         = r_a;
        n_b         = r_b;
        n_zero      = r_zero;
        n_phase_two = r_phase_two;
        n_el        = r_el;
        n_c         = r_c;
        n_t         = r_t;
        n_prod      = r_prod;
        n_neg       = r_neg;
        n_i         = r_i;
        n_sum       = r_sum;
        n_total     = r_total;
        n_log       = r_log;
        n_inv       = r_inv;
        n_out_valid = r_out_valid;

        // drop the result once the receiver takes it
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            nls_pkg::ST_IDLE: begin
                if (in_beat) begin
                    n_zero = (i_x_value == '0);
                    n_a    = nls_pkg::t_a'(i_x_value) << nls_pkg::WIDEN_SH;
                    n_b    = '0;
                end
            end
            // halve until the argument is at most two
            nls_pkg::ST_REDUCE: begin
                if (r_a > nls_pkg::TWO_A) begin
                    n_a = r_a >> 1;
                    n_b = r_b + nls_pkg::t_b'(1);
                end else begin
                    n_phase_two = (r_b != '0);
                    n_total     = '0;
                end
            end
            // first term of the series
            nls_pkg::ST_SER_INIT: begin
                n_el  = el_init;
                n_c   = -el_init;
                n_sum = r_total + nls_pkg::t_acc'(el_init);
                n_i   = nls_pkg::FIRST_INDEX;
            end
            nls_pkg::ST_MUL_C:  n_prod = mul_p;
            nls_pkg::ST_SCALE:  n_t    = nls_pkg::t_mul'(scale_sh);
            nls_pkg::ST_MUL_I:  n_prod = mul_p;
            nls_pkg::ST_DIV_START: n_neg = r_prod[nls_pkg::PROD_W-1];
            // take the new term, add it, advance the index
            nls_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    n_el  = el_new;
                    n_sum = r_sum + nls_pkg::t_acc'(el_new);
                    n_i   = r_i + nls_pkg::t_tc'(1);
                end
            end
            // scale the series at two by the halving count
            nls_pkg::ST_MUL_B: begin
                n_total     = nls_pkg::t_acc'(mul_p);
                n_phase_two = 1'b0;
            end
            // round, saturate and hand over to the result register
            nls_pkg::ST_FINISH: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_inv       = r_zero;
                    priority if (r_zero) begin
                        n_log = '0;
                    end else if (fin_sh > nls_pkg::ACC_LOG_MAX) begin
                        n_log = nls_pkg::t_log'(nls_pkg::ACC_LOG_MAX);
                    end else if (fin_sh < nls_pkg::ACC_LOG_MIN) begin
                        n_log = nls_pkg::t_log'(nls_pkg::ACC_LOG_MIN);
                    end else begin
                        n_log = nls_pkg::t_log'(fin_sh);
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= nls_pkg::ST_IDLE;
            r_out_valid  <= 1'b0;
            r_term_count <= nls_pkg::TC_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_term_count <= i_term_count;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_a         <= n_a;
        r_b         <= n_b;
        r_zero      <= n_zero;
        r_phase_two <= n_phase_two;
        r_el        <= n_el;
        r_c         <= n_c;
        r_t         <= n_t;
        r_prod      <= n_prod;
        r_neg       <= n_neg;
        r_i         <= n_i;
        r_sum       <= n_sum;
        r_total     <= n_total;
        r_log       <= n_log;
        r_inv       <= n_inv;
    end

    assign o_valid     = r_out_valid;
    assign o_log_value = r_log;
    assign o_invalid   = r_inv;
    assign o_cfg_ready = 1'b1;

endmodule

// ----- rtl/core/nls_div.sv -----
// ----------------------------------------------------------------------------
// nls_div
// Unsigned restoring divider, four quotient bits per cycle.
// ----------------------------------------------------------------------------
module nls_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  nls_pkg::t_div  i_dividend,
    input  nls_pkg::t_dsr  i_divisor,
    output logic           o_done,
    output nls_pkg::t_div  o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    nls_pkg::t_div_cnt    r_cnt;
    nls_pkg::t_div        r_quo;
    logic [nls_pkg::DIVISOR_W:0] r_rem;
    nls_pkg::t_dsr        r_dsr;

    logic [nls_pkg::DIVISOR_W:0] rem_w;
    nls_pkg::t_div        quo_w;

    // Shift in four dividend bits, trial-subtract after each one
    always_comb begin
        rem_w = r_rem;
        quo_w = r_quo;
        for (int k = 0; k < nls_pkg::DIV_RADIX; k++) begin
            rem_w = {rem_w[nls_pkg::DIVISOR_W-1:0], quo_w[nls_pkg::DIV_W-1]};
            quo_w = {quo_w[nls_pkg::DIV_W-2:0], 1'b0};
            if (rem_w >= {1'b0, r_dsr}) begin
                rem_w    = rem_w - {1'b0, r_dsr};
                quo_w[0] = 1'b1;
            end
        end
    end

    // Control: load on start, count steps, pulse done after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + nls_pkg::t_div_cnt'(1);
                if (r_cnt == nls_pkg::DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out at the top, quotient bits enter below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= quo_w;
            r_rem <= rem_w;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/core/nls_checker.sv -----
// ----------------------------------------------------------------------------
// nls_checker
// Port-level checks on the logarithm block, bound to the top level.
// ----------------------------------------------------------------------------
`include "natural_log_series_macros.svh"

module nls_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_ready,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic signed [nls_pkg::LOG_W-1:0] o_log_value,
    input logic                       o_invalid
);

    // a stalled result beat must hold its payload
    `NLS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_log_value) && $stable(o_invalid), "result beat changed while stalled")

    // an invalid result always carries zero
    `NLS_ASSERT_SAME(a_invalid_zero, i_clk, i_rst_n, o_valid && o_invalid, o_log_value == '0, "invalid result with non-zero log")

    // one item at a time: busy right after an accepted beat
    `NLS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "input taken while an item is in work")

    // reset empties the result register
    `NLS_ASSERT_AFTER_RESET(a_reset_empty, i_clk, i_rst_n, !o_valid, "result beat offered after reset")

endmodule

bind natural_log_series nls_checker u_nls_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_log_value  (o_log_value),
    .o_invalid    (o_invalid)
);

// ----- verif/nls_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nls_result_checker
// Watches the input, result and configuration channels of the logarithm
// block, predicts each result from the accepted argument and the current
// term count, and compares every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module nls_result_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [nls_pkg::X_W-1:0]           i_x_value,
    // result channel
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic signed [nls_pkg::LOG_W-1:0]  i_log_value,
    input  logic                              i_invalid,
    // configuration channel
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [nls_pkg::TC_W-1:0]          i_term_count,
    // status towards the top
    output int                                o_pending,
    output int                                o_fail_count
);

    import nls_pkg::*;

    localparam longint LOG_MAX = 64'sd2147483647;
    localparam longint LOG_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [X_W-1:0] x;
        t_log           log_value;
        logic           invalid;
    } t_log_expect;

    t_log_expect log_expect_q [$];
    t_tc         term_count;
    int          fail_total = 0;

    // Alternating log series about 1, summed in Q.30 with truncating steps
    function automatic longint log_series_sum(longint v, int unsigned terms);
        longint      step;
        longint      one_minus;
        longint      total;
        longint      prod;
        int unsigned k;
        step      = v - (longint'(1) << INNER_FRAC);
        one_minus = (longint'(1) << INNER_FRAC) - v;
        total     = step;
        for (k = 2; k < terms; k++) begin
            prod  = (step * one_minus) / (longint'(1) << INNER_FRAC);
            step  = (prod * longint'(k - 1)) / longint'(k);
            total = total + step;
        end
        return total;
    endfunction

    // Reduce the argument to at most 2, then add one series at 2 per halving
    function automatic t_log_expect predict_log(logic [X_W-1:0] x, t_tc tc);
        longint unsigned reduced;
        longint          total;
        longint          scaled;
        int unsigned     terms;
        int unsigned     halvings;
        t_log_expect     r;
        r.x   = x;
        terms = (tc > MAX_TERMS_TC) ? MAX_TERMS : int'(tc);
        if (x == '0) begin
            r.log_value = '0;
            r.invalid   = 1'b1;
            return r;
        end
        reduced  = 64'(x) << WIDEN_SH;
        halvings = 0;
        while (reduced > (64'd2 << INNER_FRAC)) begin
            reduced  = reduced >> 1;
            halvings = halvings + 1;
        end
        total = log_series_sum(longint'(reduced), terms)
              + longint'(halvings) * log_series_sum(longint'(2) << INNER_FRAC, terms);
        scaled = total / (longint'(1) << WIDEN_SH);
        if (scaled > LOG_MAX) begin
            scaled = LOG_MAX;
        end
        if (scaled < LOG_MIN) begin
            scaled = LOG_MIN;
        end
        r.log_value = t_log'(scaled);
        r.invalid   = 1'b0;
        return r;
    endfunction

    // Track the register, queue predictions, check result beats in order
    always @(posedge i_clk) begin
        t_log_expect due;
        if (!i_rst_n) begin
            term_count = TC_RESET;
            log_expect_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                term_count = i_term_count;
            end
            if (i_in_valid && i_in_ready) begin
                log_expect_q.push_back(predict_log(i_x_value, term_count));
            end
            if (i_out_valid && i_out_ready) begin
                if (log_expect_q.size() == 0) begin
                    $display("%0t: result beat with none outstanding: log %h invalid %b",
                             $time, i_log_value, i_invalid);
                    fail_total = fail_total + 1;
                end else begin
                    due = log_expect_q.pop_front();
                    if (i_log_value !== due.log_value) begin
                        $display("%0t: log_value for x=%h expected %h actual %h",
                                 $time, due.x, due.log_value, i_log_value);
                        fail_total = fail_total + 1;
                    end
                    if (i_invalid !== due.invalid) begin
                        $display("%0t: invalid for x=%h expected %b actual %b",
                                 $time, due.x, due.invalid, i_invalid);
                        fail_total = fail_total + 1;
                    end
                end
            end
        end
        o_pending    <= log_expect_q.size();
        o_fail_count <= fail_total;
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives arguments and term counts into the logarithm block in bursts, with
// a stalling receiver, and gives the verdict from the checker's fail and pending counts.
// ----------------------------------------------------------------------------
module testbench;

    import nls_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int          DRAIN_CYCLES = 64;

    logic              i_clk;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              o_ready;
    logic [X_W-1:0]    i_x_value    = '0;
    logic              o_valid;
    logic              i_ready      = 1'b0;
    t_log              o_log_value;
    logic              o_invalid;
    logic              i_cfg_valid  = 1'b0;
    logic              o_cfg_ready;
    t_tc               i_term_count = '0;

    int                pending;
    int                fail_count;
    int unsigned       cycle_count  = 0;
    int unsigned       burst_left   = 0;
    logic [31:0]       stall_bits   = '1;

    logic [X_W-1:0]    corner_x [$] = '{
        32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_8000,
        32'h0000_FFFF, 32'h0001_0000, 32'h0001_0001, 32'h0001_FFFF,
        32'h0002_0000, 32'h0002_0001, 32'h0003_0000, 32'h0004_0000,
        32'h0004_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF,
        32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000
    };

    natural_log_series u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_x_value    (i_x_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_log_value  (o_log_value),
        .o_invalid    (o_invalid),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_term_count (i_term_count)
    );

    nls_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_x_value    (i_x_value),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_log_value  (o_log_value),
        .i_invalid    (o_invalid),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_term_count (i_term_count),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Receiver: follow a random 32-bit stall pattern, refreshed whenever the low nine bits of the cycle count are zero
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count[8:0] == '0) begin
            case ($urandom_range(0, 3))
                0:       stall_bits <= '1;
                1:       stall_bits <= $urandom();
                2:       stall_bits <= $urandom() & $urandom();
                default: stall_bits <= $urandom() | $urandom();
            endcase
        end
        i_ready <= stall_bits[cycle_count[4:0]];
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Mix of zero, wide random values, values up to 2.0, halving boundaries and values near the top
    function automatic logic [X_W-1:0] rand_x();
        logic [X_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = $urandom_range(0, 32'h0002_0000);
            2:       v = (32'h1 << $urandom_range(17, 31)) + $urandom_range(0, 2) - 1;
            3:       v = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Send one argument beat; open a random gap before each new burst
    task automatic send_x(input logic [X_W-1:0] x);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left = burst_left - 1;
        i_valid   <= 1'b1;
        i_x_value <= x;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Drop valid and wait for every outstanding result beat
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // One configuration beat, only while the block is idle
    task automatic set_term_count(input t_tc tc);
        i_cfg_valid  <= 1'b1;
        i_term_count <= tc;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
    endtask

    initial begin
        int unsigned n;
        t_tc         tc;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corner arguments at the reset term count
        for (n = 0; n < corner_x.size(); n++) begin
            send_x(corner_x[n]);
        end
        settle();

        // degenerate and shortest series lengths
        for (n = 0; n < 4; n++) begin
            set_term_count(t_tc'(n));
            send_x(32'h0000_0001);
            send_x(32'hFFFF_FFFF);
            repeat (4) send_x(rand_x());
            settle();
        end

        // longest series, one reduced and one unreduced argument
        set_term_count(MAX_TERMS_TC);
        send_x(32'h0000_8000);
        send_x(32'hFFFF_FFFF);
        settle();

        // random arguments over a spread of short series lengths
        repeat (8) begin
            tc = t_tc'($urandom_range(4, 48));
            set_term_count(tc);
            repeat (12) send_x(rand_x());
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/nls_pkg.sv
rtl/core/nls_div.sv
rtl/core/natural_log_series.sv
rtl/core/nls_checker.sv
verif/nls_result_checker.sv
verif/testbench.sv
